// File: rtl/cdt_pkg.sv
// Package for the countdown timer core: operation and state codes, reset values
// and the constants of the millisecond arithmetic. It depends on nothing else.
`default_nettype none

package cdt_pkg;

    localparam int DurW = 17;
    localparam int VerW = 16;

    localparam logic [3:0] OP_TICK         = 4'd0;
    localparam logic [3:0] OP_START        = 4'd1;
    localparam logic [3:0] OP_PAUSE        = 4'd2;
    localparam logic [3:0] OP_RESUME       = 4'd3;
    localparam logic [3:0] OP_RESET        = 4'd4;
    localparam logic [3:0] OP_ADJUST       = 4'd5;
    localparam logic [3:0] OP_SET_DURATION = 4'd6;
    localparam logic [3:0] OP_SET_RUNNING  = 4'd7;
    localparam logic [3:0] OP_SET_ADJUST   = 4'd8;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_PAUSED  = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    localparam logic [DurW-1:0] DEFAULT_DURATION_SEC = 17'd1500;
    localparam logic [DurW-1:0] MAX_DURATION_RESET   = 17'd7200;
    localparam logic [DurW-1:0] MIN_DURATION_SEC     = 17'd60;
    localparam logic [DurW-1:0] REMAIN_MAX           = 17'd131071;
    localparam logic [VerW-1:0] VERSION_RESET        = 16'd1;

    localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
    localparam logic [18:0] SEC_PER_MIN = 19'sd60;

    // Differences at or above this many milliseconds saturate the seconds count.
    localparam logic [31:0] SAT_MS      = 32'd131072000;
    // x / 1000 == (x * MS_RECIP) >> MS_SHIFT for every 32-bit x.
    localparam logic [28:0] MS_RECIP    = 29'h10624DD3;
    localparam int          MS_SHIFT    = 38;

    typedef struct packed {
        logic            not_expired;
        logic [DurW-1:0] secs_left;
        logic [31:0]     end_ms;
    } t_time_res;

endpackage

`default_nettype wire

// File: rtl/cdt_time_calc.sv
// Millisecond arithmetic of the timer: seconds left until the end time and a
// fresh end time from the current time. Uses cdt_pkg.
`default_nettype none

module cdt_time_calc (
    input  wire logic [31:0]            i_now_ms,
    input  wire logic [31:0]            i_end_ms,
    input  wire logic [cdt_pkg::DurW-1:0] i_remaining,
    output cdt_pkg::t_time_res          o_res
);
    import cdt_pkg::*;

    logic [31:0] diff;
    logic [55:0] prod;
    logic [26:0] span;

    always_comb begin
        diff = i_end_ms - i_now_ms;
        prod = 56'(diff[26:0]) * 56'(MS_RECIP);
        span = 27'(i_remaining) * 27'(MS_PER_SEC);

        o_res.not_expired = i_end_ms > i_now_ms;
        if (diff >= SAT_MS) begin
            o_res.secs_left = REMAIN_MAX;
        end else begin
            o_res.secs_left = prod[MS_SHIFT +: DurW];
        end
        o_res.end_ms = i_now_ms + {5'd0, span};
    end

endmodule

`default_nettype wire

// File: rtl/cdt_dur_calc.sv
// Duration update: either the encoder delta in minutes added to the current
// duration, or a new value in seconds, clamped to the minimum and then to the
// configured maximum. Uses cdt_pkg.
`default_nettype none

module cdt_dur_calc (
    input  wire logic [cdt_pkg::DurW-1:0] i_duration,
    input  wire logic signed [7:0]        i_delta_minutes,
    input  wire logic [31:0]              i_value,
    input  wire logic                     i_use_value,
    input  wire logic [cdt_pkg::DurW-1:0] i_max_dur,
    output logic [cdt_pkg::DurW-1:0]      o_new_dur
);
    import cdt_pkg::*;

    logic signed [18:0] delta_ext;
    logic signed [18:0] adj;
    logic signed [32:0] cand;
    logic signed [32:0] raised;
    logic signed [32:0] lowered;

    always_comb begin
        delta_ext = 19'(i_delta_minutes);
        adj       = $signed({2'b00, i_duration}) + delta_ext * $signed(SEC_PER_MIN);
        if (i_use_value) begin
            cand = $signed({1'b0, i_value});
        end else begin
            cand = 33'(adj);
        end
        if (cand < $signed({16'd0, MIN_DURATION_SEC})) begin
            raised = $signed({16'd0, MIN_DURATION_SEC});
        end else begin
            raised = cand;
        end
        if (raised > $signed({16'd0, i_max_dur})) begin
            lowered = $signed({16'd0, i_max_dur});
        end else begin
            lowered = raised;
        end
        o_new_dur = lowered[DurW-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/countdown_timer_pause_resume_core.sv
// Top level of the countdown timer: input register, timer state, result register
// and the handshakes. Uses cdt_pkg, cdt_time_calc and cdt_dur_calc.
//
//   Channel | Direction | Handshake             | Beat
//   in      | input     | i_in_valid/o_in_stall | operation, time, delta, mode, value
//   out     | output    | o_out_valid/i_out_stall | state, remaining, duration, flags
//   cfg     | input     | i_cfg_we              | max_duration_sec
//
// Each beat is taken into the input register and worked out while it sits there; the
// timer state and the result register are updated together once the result register is
// free. One beat a cycle is taken while the result channel does not stall.
// Reset is synchronous and active low; it empties both registers and restores the
// timer state. A stalled result holds the result register and, once the input
// register is also full, stalls the input channel.
`default_nettype none

module countdown_timer_pause_resume_core (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [3:0]               i_operation,
    input  wire logic [31:0]              i_now_ms,
    input  wire logic signed [7:0]        i_delta_minutes,
    input  wire logic                     i_in_timer_mode,
    input  wire logic [31:0]              i_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [1:0]                    o_timer_state,
    output logic [cdt_pkg::DurW-1:0]      o_remaining_sec,
    output logic [cdt_pkg::DurW-1:0]      o_duration_sec,
    output logic                          o_adjust_on,
    output logic                          o_done_pulse,
    output logic [cdt_pkg::VerW-1:0]      o_config_version,
    input  wire logic                     i_cfg_we,
    input  wire logic [cdt_pkg::DurW-1:0] i_cfg_wdata
);
    import cdt_pkg::*;

    logic                r_in_valid;
    logic [3:0]          r_op;
    logic [31:0]         r_now;
    logic signed [7:0]   r_delta;
    logic                r_tmode;
    logic [31:0]         r_value;

    logic [DurW-1:0]     r_max_dur;
    logic [1:0]          r_mode;
    logic [31:0]         r_end;
    logic [DurW-1:0]     r_rem;
    logic [DurW-1:0]     r_dur;
    logic                r_adj;
    logic [VerW-1:0]     r_ver;

    logic                r_out_valid;
    logic                r_pulse;

    logic [1:0]          n_mode;
    logic [31:0]         n_end;
    logic [DurW-1:0]     n_rem;
    logic [DurW-1:0]     n_dur;
    logic                n_adj;
    logic [VerW-1:0]     n_ver;
    logic                n_pulse;

    logic                out_free;
    logic                fire;
    logic                do_dur;
    logic [DurW-1:0]     time_rem;
    logic [DurW-1:0]     new_dur;
    t_time_res           tres;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign time_rem   = (r_op == OP_START) ? r_dur : r_rem;

    cdt_time_calc u_time (
        .i_now_ms    (r_now),
        .i_end_ms    (r_end),
        .i_remaining (time_rem),
        .o_res       (tres)
    );

    cdt_dur_calc u_dur (
        .i_duration      (r_dur),
        .i_delta_minutes (r_delta),
        .i_value         (r_value),
        .i_use_value     (r_op == OP_SET_DURATION),
        .i_max_dur       (r_max_dur),
        .o_new_dur       (new_dur)
    );

    always_comb begin
        n_mode  = r_mode;
        n_end   = r_end;
        n_rem   = r_rem;
        n_dur   = r_dur;
        n_adj   = r_adj;
        n_ver   = r_ver;
        n_pulse = 1'b0;
        do_dur  = 1'b0;

        unique case (r_op) inside
            OP_TICK: begin
                do_dur = r_tmode && r_adj && (r_delta != 8'sd0);
            end
            OP_ADJUST, OP_SET_DURATION: begin
                do_dur = 1'b1;
            end
            default: begin
                do_dur = 1'b0;
            end
        endcase

        if (do_dur) begin
            n_dur = new_dur;
            n_ver = r_ver + 1'b1;
            if (r_mode == ST_IDLE || r_mode == ST_DONE) begin
                n_rem = new_dur;
            end
        end

        unique case (r_op)
            OP_TICK: begin
                if (r_mode == ST_RUNNING) begin
                    if (tres.not_expired) begin
                        n_rem = tres.secs_left;
                    end else begin
                        n_rem   = '0;
                        n_mode  = ST_DONE;
                        n_pulse = 1'b1;
                    end
                end
            end
            OP_START: begin
                n_mode = ST_RUNNING;
                n_rem  = r_dur;
                n_end  = tres.end_ms;
            end
            OP_PAUSE: begin
                if (r_mode == ST_RUNNING) begin
                    n_rem  = tres.not_expired ? tres.secs_left : '0;
                    n_mode = ST_PAUSED;
                end
            end
            OP_RESUME: begin
                if (r_mode == ST_PAUSED) begin
                    n_mode = ST_RUNNING;
                    n_end  = tres.end_ms;
                end
            end
            OP_RESET: begin
                n_mode = ST_IDLE;
                n_rem  = r_dur;
            end
            OP_SET_RUNNING: begin
                if (r_value[0]) begin
                    if (r_mode != ST_RUNNING) begin
                        n_mode = ST_RUNNING;
                        n_end  = tres.end_ms;
                    end
                end else if (r_mode == ST_RUNNING) begin
                    n_rem  = tres.not_expired ? tres.secs_left : '0;
                    n_mode = ST_PAUSED;
                end
            end
            OP_SET_ADJUST: begin
                n_adj = r_value[0];
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_dur   <= MAX_DURATION_RESET;
            r_mode      <= ST_IDLE;
            r_end       <= '0;
            r_rem       <= DEFAULT_DURATION_SEC;
            r_dur       <= DEFAULT_DURATION_SEC;
            r_adj       <= 1'b0;
            r_ver       <= VERSION_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_dur <= i_cfg_wdata;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_mode <= n_mode;
                r_end  <= n_end;
                r_rem  <= n_rem;
                r_dur  <= n_dur;
                r_adj  <= n_adj;
                r_ver  <= n_ver;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op    <= i_operation;
            r_now   <= i_now_ms;
            r_delta <= i_delta_minutes;
            r_tmode <= i_in_timer_mode;
            r_value <= i_value;
        end
        if (fire) begin
            r_pulse <= n_pulse;
        end
    end

    // The result fields, but for the done pulse, are the timer state registers themselves; all are held while stalled.
    assign o_out_valid      = r_out_valid;
    assign o_timer_state    = r_mode;
    assign o_remaining_sec  = r_rem;
    assign o_duration_sec   = r_dur;
    assign o_adjust_on      = r_adj;
    assign o_done_pulse     = r_pulse;
    assign o_config_version = r_ver;

endmodule

`default_nettype wire

// File: rtl/cdt_checker.sv
// Port-level checks for the countdown timer core, attached by the bind below.
// Uses cdt_pkg for the state codes.
`default_nettype none

module cdt_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic [1:0]               o_timer_state,
    input wire logic [cdt_pkg::DurW-1:0] o_remaining_sec,
    input wire logic                     o_done_pulse,
    input wire logic [cdt_pkg::VerW-1:0] o_config_version
);
    import cdt_pkg::*;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat shown straight after reset");

    a_pulse_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_pulse) |-> (o_timer_state == ST_DONE))
        else $error("done pulse without done state");

    a_pulse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_pulse) |-> (o_remaining_sec == '0))
        else $error("done pulse with time remaining");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_config_version) && $stable(o_timer_state)))
        else $error("stalled result beat changed");

endmodule

bind countdown_timer_pause_resume_core cdt_checker u_cdt_checker (.*);

`default_nettype wire
